>>> hdl/hbs_pkg.sv
package hbs_pkg;

  localparam int unsigned GridCols = 32;
  localparam int unsigned GridRows = 32;
  localparam int unsigned XW = $clog2(GridCols);
  localparam int unsigned ZW = $clog2(GridRows);
  localparam int unsigned AW = XW + ZW;
  localparam int unsigned Depth = GridCols * GridRows;
  localparam int unsigned HW = 24;
  localparam int unsigned CellUnits = 1280;
  localparam int unsigned QDepth = 4;

  localparam logic CFG_ORIGIN_X = 1'b0;
  localparam logic CFG_ORIGIN_Z = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_BRUSH  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [XW-1:0]         x0;
    logic [ZW-1:0]         z0;
    logic [XW-1:0]         x1;
    logic [ZW-1:0]         z1;
    logic [10:0]           tx;
    logic [10:0]           tz;
    logic signed [8:0]     bx;
    logic signed [8:0]     bz;
    logic signed [HW-1:0]  hv;
  } cmd_t;

  function automatic logic [16:0] brush_weight(input logic [1:0] ax, input logic [1:0] az);
    logic [16:0] w;
    w = 17'd0;
    case ({ax, az})
      4'b0000: w = 17'd32768;
      4'b0001, 4'b0100: w = 17'd21845;
      4'b0010, 4'b1000: w = 17'd10923;
      4'b0101: w = 17'd17321;
      4'b0110, 4'b1001: w = 17'd8344;
      4'b1010: w = 17'd1874;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

endpackage

>>> hdl/hbs_ram.sv
module hbs_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> hdl/hbs_front.sv
module hbs_front import hbs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_index_i,
  input  logic [HW-1:0]   cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      kind_i,
  input  logic [4:0]      cell_x_i,
  input  logic [4:0]      cell_z_i,
  input  logic [HW-1:0]   pos_x_i,
  input  logic [HW-1:0]   pos_z_i,
  input  logic [HW-1:0]   height_value_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output cmd_t            cmd_o
);
  logic signed [HW-1:0] org_x_q, org_z_q;
  logic stg_q;
  cmd_t stg_cmd_q;
  logic signed [HW-1:0] px, pz;
  logic signed [26:0] u, v, bxs, bzs;
  logic [15:0] uc, vc;
  logic [XW-1:0] xq;
  logic [ZW-1:0] zq;
  logic [10:0] ur, vr;
  logic [31:0] um, vm;
  logic bxn, bzn;
  logic [26:0] bxa, bza;
  logic [26:0] bxq, bzq;
  logic [47:0] bxm, bzm;
  cmd_t c;

  assign cfg_ready_o = 1'b1;
  assign px = pos_x_i;
  assign pz = pos_z_i;

  always_comb begin
    u = 27'(px) - 27'(org_x_q) + 27'(GridCols * 640);
    v = 27'(org_z_q) - 27'(pz) + 27'(GridRows * 640);
    if (u < 0) uc = '0;
    else if (u > 27'((GridCols - 1) * CellUnits)) uc = 16'((GridCols - 1) * CellUnits);
    else uc = u[15:0];
    if (v < 0) vc = '0;
    else if (v > 27'((GridRows - 1) * CellUnits)) vc = 16'((GridRows - 1) * CellUnits);
    else vc = v[15:0];
    um = 32'(uc) * 32'd52429;
    vm = 32'(vc) * 32'd52429;
    xq = XW'(um >> 26);
    zq = ZW'(vm >> 26);
    ur = 11'(uc - 16'(32'(xq) * CellUnits));
    vr = 11'(vc - 16'(32'(zq) * CellUnits));
    bxs = 27'(px) + 27'(10 * CellUnits);
    bzs = 27'(10 * CellUnits) - 27'(pz);
    bxn = bxs[26];
    bzn = bzs[26];
    bxa = bxn ? -bxs : bxs;
    bza = bzn ? -bzs : bzs;
    // divide by 256 with a shift, then by 5 with a reciprocal
    bxm = 48'(bxa[23:8]) * 48'd52429;
    bzm = 48'(bza[23:8]) * 48'd52429;
    bxq = 27'(bxm >> 18);
    bzq = 27'(bzm >> 18);
    // far-off centres only need to stay off the grid
    if (bxq > 27'd255) bxq = 27'd255;
    if (bzq > 27'd255) bzq = 27'd255;
    c.kind = kind_e'(kind_i);
    c.hv = height_value_i;
    c.tx = ur;
    c.tz = vr;
    c.bx = bxn ? -9'(bxq) : 9'(bxq);
    c.bz = bzn ? -9'(bzq) : 9'(bzq);
    if (kind_e'(kind_i) == KIND_LOAD) begin
      c.x0 = XW'(cell_x_i);
      c.z0 = ZW'(cell_z_i);
      c.x1 = c.x0;
      c.z1 = c.z0;
    end else begin
      c.x0 = xq;
      c.z0 = zq;
      c.x1 = (32'(xq) + 1 < GridCols) ? xq + 1'b1 : xq;
      c.z1 = (32'(zq) + 1 < GridRows) ? zq + 1'b1 : zq;
    end
  end

  assign in_ready_o = !stg_q || cmd_ready_i;
  assign cmd_valid_o = stg_q;
  assign cmd_o = stg_cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_z_q <= '0;
      stg_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_ORIGIN_X) org_x_q <= cfg_data_i;
        else org_z_q <= cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        stg_q <= (kind_e'(kind_i) != KIND_NONE) &&
                 !(kind_e'(kind_i) == KIND_LOAD &&
                   (32'(cell_x_i) >= GridCols || 32'(cell_z_i) >= GridRows));
      end else if (cmd_ready_i) begin
        stg_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) stg_cmd_q <= c;
  end
endmodule

>>> hdl/hbs_queue.sv
module hbs_queue import hbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_data_o
);
  localparam int unsigned PW = $clog2(QDepth);
  cmd_t buf_q [QDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0] cnt_q;
  logic push, pop;
  assign in_ready_o = cnt_q != (PW+1)'(QDepth);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o = buf_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= in_data_i;
  end
endmodule

>>> hdl/hbs_back.sv
module hbs_back import hbs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  cmd_t            cmd_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [HW-1:0]   res_data_o
);
  typedef enum logic [3:0] {
    ST_IDLE, ST_SRD, ST_SACC, ST_SMUL, ST_SDIV, ST_SOUT, ST_BRD, ST_BWAIT, ST_BMUL, ST_BWR
  } state_e;

  state_e st_q;
  cmd_t c_q;
  logic [1:0] k_q;
  logic [2:0] dx_q, dz_q;
  logic signed [HW-1:0] rd0_q, rd1_q;
  logic signed [35:0] h0_q, h1_q;
  logic signed [47:0] p_q;
  logic signed [57:0] acc_q;
  logic [28:0] dq_q;
  logic signed [47:0] bp_q;
  logic signed [HW-1:0] h_q;
  logic rv_q;
  logic [HW-1:0] rd_q;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [HW-1:0] wdata, rdata;
  logic signed [9:0] cx, cz;
  logic inb;
  logic [1:0] ax, az;
  logic signed [11:0] w0x, w1x;
  logic signed [57:0] sum;
  logic [59:0] prod;
  logic signed [25:0] qd;
  logic signed [HW-1:0] rs;
  logic signed [25:0] nh;
  logic signed [HW-1:0] nhs;

  hbs_ram #(.Width(HW), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  always_comb begin
    cx = 10'(c_q.bx) + 10'(dx_q) - 10'sd2;
    cz = 10'(c_q.bz) + 10'(dz_q) - 10'sd2;
    inb = cx >= 0 && cx < 10'(GridCols) && cz >= 0 && cz < 10'(GridRows);
    ax = (dx_q >= 3'd2) ? 2'(dx_q - 3'd2) : 2'(3'd2 - dx_q);
    az = (dz_q >= 3'd2) ? 2'(dz_q - 3'd2) : 2'(3'd2 - dz_q);
    case (k_q)
      2'd0: raddr = {c_q.x0, c_q.z0};
      2'd1: raddr = {c_q.x1, c_q.z0};
      2'd2: raddr = {c_q.x0, c_q.z1};
      default: raddr = {c_q.x1, c_q.z1};
    endcase
    if (st_q == ST_BRD || st_q == ST_BWAIT || st_q == ST_BMUL || st_q == ST_BWR)
      raddr = {XW'(cx), ZW'(cz)};
    w1x = 12'(c_q.tx);
    w0x = 12'(CellUnits) - w1x;
    // rounding term plus an offset of 25 * 2^23 * 2^16 keeps the sum non-negative
    sum = acc_q + 58'sd13743896166400;
    // floor divide by 25 through a reciprocal, then remove the offset
    prod = 60'(dq_q) * 60'd687194768;
    qd = $signed(prod[59:34]) - 26'sd8388608;
    if (qd > 26'sd8388607) rs = 24'sh7FFFFF;
    else if (qd < -26'sd8388608) rs = -24'sd8388608;
    else rs = qd[HW-1:0];
    nh = 26'(h_q) + 26'((bp_q + 48'sd32768) >>> 16);
    if (nh > 26'sd8388607) nhs = 24'sh7FFFFF;
    else if (nh < -26'sd8388608) nhs = -24'sd8388608;
    else nhs = nh[HW-1:0];
    we = 1'b0;
    waddr = {c_q.x0, c_q.z0};
    wdata = c_q.hv;
    if (st_q == ST_IDLE && cmd_valid_i && cmd_i.kind == KIND_LOAD) begin
      we = 1'b1;
      waddr = {cmd_i.x0, cmd_i.z0};
      wdata = cmd_i.hv;
    end else if (st_q == ST_BWR) begin
      we = 1'b1;
      waddr = {XW'(cx), ZW'(cz)};
      wdata = nhs;
    end
  end

  assign cmd_ready_o = st_q == ST_IDLE;
  assign res_valid_o = rv_q;
  assign res_data_o = rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      rv_q <= 1'b0;
      k_q <= '0;
      dx_q <= '0;
      dz_q <= '0;
    end else begin
      if (rv_q && res_ready_i && st_q != ST_SOUT) rv_q <= 1'b0;
      case (st_q)
        ST_IDLE: if (cmd_valid_i) begin
          k_q <= '0;
          dx_q <= '0;
          dz_q <= '0;
          case (cmd_i.kind)
            KIND_SAMPLE: st_q <= ST_SRD;
            KIND_BRUSH:  st_q <= ST_BRD;
            default:     st_q <= ST_IDLE;
          endcase
        end
        ST_SRD: begin
          k_q <= k_q + 1'b1;
          if (k_q == 2'd3) st_q <= ST_SACC;
        end
        ST_SACC: st_q <= ST_SMUL;
        ST_SMUL: st_q <= ST_SDIV;
        ST_SDIV: st_q <= ST_SOUT;
        ST_SOUT: if (!rv_q || res_ready_i) begin
          rv_q <= 1'b1;
          st_q <= ST_IDLE;
        end
        ST_BRD: begin
          if (inb) st_q <= ST_BWAIT;
          else if (dz_q == 3'd4) begin
            dz_q <= '0;
            dx_q <= dx_q + 1'b1;
            if (dx_q == 3'd4) st_q <= ST_IDLE;
          end else dz_q <= dz_q + 1'b1;
        end
        ST_BWAIT: st_q <= ST_BMUL;
        ST_BMUL: st_q <= ST_BWR;
        ST_BWR: begin
          st_q <= (dz_q == 3'd4 && dx_q == 3'd4) ? ST_IDLE : ST_BRD;
          if (dz_q == 3'd4) begin
            dz_q <= '0;
            dx_q <= dx_q + 1'b1;
          end else dz_q <= dz_q + 1'b1;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && cmd_valid_i) c_q <= cmd_i;
    if (st_q == ST_SRD) begin
      rd0_q <= rdata;
      rd1_q <= rd0_q;
      case (k_q)
        2'd3: h0_q <= 36'(rd1_q) * 36'(w0x) + 36'(rd0_q) * 36'(w1x);
        default: ;
      endcase
    end
    if (st_q == ST_SACC) begin
      h1_q <= 36'(rd0_q) * 36'(w0x) + 36'(signed'(rdata)) * 36'(w1x);
      p_q <= 48'(h0_q) * 48'(12'(CellUnits) - 12'(c_q.tz));
    end
    if (st_q == ST_SACC) acc_q <= '0;
    if (st_q == ST_SMUL) acc_q <= 58'(p_q) + 58'(h1_q) * 58'(12'(c_q.tz));
    if (st_q == ST_SDIV) dq_q <= sum[44:16];
    if (st_q == ST_SOUT && (!rv_q || res_ready_i)) rd_q <= rs;
    if (st_q == ST_BMUL) begin
      h_q <= rdata;
      bp_q <= 48'(26'(c_q.hv) - 26'(signed'(rdata))) * 48'(signed'({1'b0, brush_weight(ax, az)}));
    end
  end
endmodule

>>> hdl/heightmap_bilinear_sample_and_brush_top.sv
// sample: four reads on the single memory read port; the back end takes no new
// command until the result is registered (the queue holds waiting commands)
// brush: read-modify-write of each in-grid patch cell via BRD, BWAIT, BMUL, BWR states
// reset clears origins to zero and empties the queue; height memory is not cleared
module heightmap_bilinear_sample_and_brush_top import hbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // cell_x, cell_z, pos_x, pos_z, height_value
  input  logic [1:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // sampled_height
);
  logic fv, fr, bv, br;
  cmd_t fc, bc;

  hbs_front u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .kind_i(s_axis_tuser), .cell_x_i(s_axis_tdata[4:0]), .cell_z_i(s_axis_tdata[9:5]),
    .pos_x_i(s_axis_tdata[33:10]), .pos_z_i(s_axis_tdata[57:34]),
    .height_value_i(s_axis_tdata[81:58]),
    .cmd_valid_o(fv), .cmd_ready_i(fr), .cmd_o(fc)
  );

  hbs_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(fv), .in_ready_o(fr), .in_data_i(fc),
    .out_valid_o(bv), .out_ready_i(br), .out_data_o(bc)
  );

  hbs_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(bv), .cmd_ready_o(br), .cmd_i(bc),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_data_o(m_axis_tdata)
  );
endmodule

>>> tb/heightmap_bilinear_sample_and_brush_top_tb.sv
`timescale 1ns / 1ps

module heightmap_bilinear_sample_and_brush_top_tb;
  import hbs_pkg::*;

  localparam int   STALL_LIMIT = 5000;

  class height_scoreboard;
    logic signed [23:0] cells [1024];
    longint org_x;
    longint org_z;
    logic [23:0] pending [$];
    int mismatches;
    int half_wt [3][3] = '{'{32768, 21845, 10923}, '{21845, 17321, 8344},
                           '{10923, 8344, 1874}};

    function longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b != 0) && ((a < 0) != (b < 0))) q = q - 1;
      return q;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint rd(longint x, longint z);
      return longint'(cells[x * 32 + z]);
    endfunction

    function logic [23:0] bilinear(longint px, longint pz);
      longint u, v, x0, z0, x1, z1, tx, tz, h0, h1, acc;
      u = clip(px - org_x + 32 * 640, 0, 31 * 1280);
      v = clip(org_z - pz + 32 * 640, 0, 31 * 1280);
      x0 = u / 1280;
      tx = u % 1280;
      z0 = v / 1280;
      tz = v % 1280;
      x1 = (x0 + 1 < 32) ? x0 + 1 : x0;
      z1 = (z0 + 1 < 32) ? z0 + 1 : z0;
      h0 = rd(x0, z0) * (1280 - tx) + rd(x1, z0) * tx;
      h1 = rd(x0, z1) * (1280 - tx) + rd(x1, z1) * tx;
      acc = h0 * (1280 - tz) + h1 * tz;
      return 24'(clip(fdiv(acc + 819200, 1638400), -8388608, 8388607));
    endfunction

    function void blend_patch(longint px, longint pz, longint target);
      longint cx, cz, x, z, h, nh;
      int a;
      cx = (px + 12800) / 1280;
      cz = (12800 - pz) / 1280;
      for (int dx = -2; dx <= 2; dx++) begin
        for (int dz = -2; dz <= 2; dz++) begin
          x = cx + dx;
          z = cz + dz;
          if (x >= 0 && x < 32 && z >= 0 && z < 32) begin
            h = rd(x, z);
            a = half_wt[dx < 0 ? -dx : dx][dz < 0 ? -dz : dz];
            nh = h + fdiv((target - h) * a + 32768, 65536);
            cells[x * 32 + z] = 24'(clip(nh, -8388608, 8388607));
          end
        end
      end
    endfunction

    function void note_item(kind_e k, logic [4:0] cx, logic [4:0] cz,
                            logic signed [23:0] px, logic signed [23:0] pz,
                            logic signed [23:0] hv);
      case (k)
        KIND_LOAD: cells[cx * 32 + cz] = hv;
        KIND_SAMPLE: pending = {pending, bilinear(px, pz)};
        KIND_BRUSH: blend_patch(px, pz, hv);
        default: ;
      endcase
    endfunction

    function void check_result(logic [23:0] got);
      logic [23:0] want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("sampled_height mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_index_i;
  logic [23:0] cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [23:0] m_axis_tdata;

  height_scoreboard heights;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int quiet_cycles;

  heightmap_bilinear_sample_and_brush_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side: stalls, long hold-off and checking
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) heights.check_result(m_axis_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic write_reg(logic idx, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(kind_e k, logic [4:0] cx, logic [4:0] cz,
                           logic signed [23:0] px, logic signed [23:0] pz,
                           logic signed [23:0] hv);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= k;
    s_axis_tdata <= {6'd0, hv, pz, px, cz, cx};
    do @(posedge clk_i); while (!s_axis_tready);
    heights.note_item(k, cx, cz, px, pz, hv);
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (heights.pending.size() != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
  endtask

  function automatic logic [23:0] near_pos();
    return 24'($signed($urandom_range(45000)) - 17000);
  endfunction

  task automatic random_items(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 25)
        send_item(KIND_LOAD, 5'($urandom), 5'($urandom), near_pos(), near_pos(),
                  ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(20000)));
      else if (r < 62)
        send_item(KIND_SAMPLE, 5'($urandom), 5'($urandom),
                  24'($signed(near_pos()) + 24'(heights.org_x)),
                  24'($signed(near_pos()) + 24'(heights.org_z)), 24'($urandom));
      else if (r < 70)
        send_item(KIND_SAMPLE, 5'($urandom), 5'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom));
      else if (r < 94)
        send_item(KIND_BRUSH, 5'($urandom), 5'($urandom), near_pos(), near_pos(),
                  ($urandom_range(4) == 0) ? 24'($urandom) : 24'($urandom_range(30000)));
      else
        send_item(KIND_NONE, 5'($urandom), 5'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom));
    end
  endtask

  initial begin
    heights = new();
    heights.org_x = 0;
    heights.org_z = 0;
    hold_left = 0;
    send_idle_pct = 7;
    recv_stall_pct = 71;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ORIGIN_X;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = KIND_LOAD;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every cell gets a height before anything reads it
    for (int x = 0; x < 32; x++)
      for (int z = 0; z < 32; z++)
        send_item(KIND_LOAD, 5'(x), 5'(z), '0, '0, 24'($urandom_range(4000)));

    send_item(KIND_LOAD, 5'd31, 5'd31, '0, '0, 24'sh7fffff);
    send_item(KIND_LOAD, 5'd0, 5'd0, '0, '0, 24'sh800000);
    send_item(KIND_LOAD, 5'd31, 5'd0, '0, '0, 24'sh7fffff);
    send_item(KIND_SAMPLE, '0, '0, 24'sh7fffff, 24'sh800000, '0);
    send_item(KIND_SAMPLE, '0, '0, 24'sh800000, 24'sh7fffff, '0);
    send_item(KIND_SAMPLE, '0, '0, 24'sh7fffff, 24'sh7fffff, '0);
    send_item(KIND_SAMPLE, '0, '0, 24'sh800000, 24'sh800000, '0);
    send_item(KIND_SAMPLE, '0, '0, 24'd640, -24'sd640, '0);
    send_item(KIND_SAMPLE, '0, '0, 24'd0, 24'd0, '0);
    send_item(KIND_BRUSH, '0, '0, 24'd0, 24'd0, 24'sh7fffff);
    send_item(KIND_BRUSH, '0, '0, -24'sd12800, 24'd12800, 24'sh800000);
    send_item(KIND_BRUSH, '0, '0, 24'd26880, -24'sd26880, 24'd100);
    send_item(KIND_BRUSH, '0, '0, 24'sh7fffff, 24'sh800000, 24'd5);
    send_item(KIND_BRUSH, '0, '0, -24'sd1279, 24'd1279, 24'd0);
    send_item(KIND_SAMPLE, '0, '0, 24'd0, 24'd0, '0);
    send_item(KIND_SAMPLE, '0, '0, -24'sd20480, 24'd20480, '0);
    send_item(KIND_NONE, 5'h1f, 5'h1f, 24'hffffff, 24'hffffff, 24'hffffff);
    random_items(150);
    drain_and_settle();

    send_idle_pct = 71;
    recv_stall_pct = 7;
    write_reg(CFG_ORIGIN_X, 24'sh800000);
    write_reg(CFG_ORIGIN_Z, 24'sh7fffff);
    heights.org_x = -8388608;
    heights.org_z = 8388607;
    random_items(150);
    drain_and_settle();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_ORIGIN_X, 24'sh7fffff);
    write_reg(CFG_ORIGIN_Z, 24'sh800000);
    heights.org_x = 8388607;
    heights.org_z = -8388608;
    hold_left = 400;
    for (int n = 0; n < 40; n++)
      send_item(KIND_SAMPLE, '0, '0, 24'($signed(near_pos()) + 24'sh7fffff),
                24'($signed(near_pos()) + 24'sh800000), '0);
    random_items(160);
    drain_and_settle();

    write_reg(CFG_ORIGIN_X, 24'($signed($urandom_range(20000)) - 10000));
    heights.org_x = $signed(cfg_data_i);
    write_reg(CFG_ORIGIN_Z, 24'($signed($urandom_range(20000)) - 10000));
    heights.org_z = $signed(cfg_data_i);
    random_items(200);
    s_axis_tvalid <= 1'b0;
    while (heights.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (heights.mismatches == 0 && heights.pending.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
